[hw/rtl/grle_pkg.sv]
// Package for the grid run-length expander: widths, marker characters,
// register indexes, controller states and the control/status structs.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps

package grle_pkg;

    localparam int BYTE_W     = 8;
    localparam int REP_W      = 9;
    localparam int COL_W      = 10;
    localparam int LINE_W     = 16;
    localparam int WIDTH_W    = 11;
    localparam int PLACE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [BYTE_W-1:0]  CHAR_P    = 8'h50;
    localparam logic [BYTE_W-1:0]  CHAR_K    = 8'h4B;
    localparam logic [WIDTH_W-1:0] WIDTH_MIN = 11'd8;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX = 11'd1024;
    localparam logic [WIDTH_W-1:0] DIST_NONE = 11'h7FF;
    localparam logic [LINE_W-1:0]  LINE_MAX  = 16'hFFFF;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_WIDTH  = 3'd0,
        REG_ENTRY_LINE  = 3'd1,
        REG_ENTRY_PLACE = 3'd2,
        REG_EXIT_LINE   = 3'd3,
        REG_EXIT_PLACE  = 3'd4,
        REG_SEPARATOR   = 3'd5,
        REG_WALL        = 3'd6,
        REG_PATH        = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIST,
        ST_SEG,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic [WIDTH_W-1:0] line_width;
        logic [LINE_W-1:0]  entry_line;
        logic [PLACE_W-1:0] entry_place;
        logic [LINE_W-1:0]  exit_line;
        logic [PLACE_W-1:0] exit_place;
        logic [BYTE_W-1:0]  separator_byte;
        logic [BYTE_W-1:0]  wall_byte;
        logic [BYTE_W-1:0]  path_byte;
    } t_cfg;

    typedef struct packed {
        logic load_word;
        logic load_err;
        logic calc_dist;
        logic load_seg;
    } t_cmd;

    typedef struct packed {
        logic word_ok;
        logic seg_last;
    } t_sts;

endpackage

[hw/rtl/grle_if.sv]
// Channel interfaces of the grid run-length expander: code words in,
// segments out, and the configuration write channel. Depends on grle_pkg.
`timescale 1ns / 1ps

interface grle_word_if;
    logic                       valid;
    logic                       ready;
    logic [grle_pkg::BYTE_W-1:0] lead_byte;
    logic [grle_pkg::BYTE_W-1:0] symbol;
    logic [grle_pkg::BYTE_W-1:0] count;

    modport source (output valid, output lead_byte, output symbol, output count,
                    input ready);
    modport sink   (input valid, input lead_byte, input symbol, input count,
                    output ready);
endinterface

interface grle_seg_if;
    logic                        valid;
    logic                        ready;
    logic [grle_pkg::BYTE_W-1:0] character;
    logic [grle_pkg::REP_W-1:0]  repeat_res;
    logic                        line_end;
    logic                        last;
    logic                        error;

    modport source (output valid, output character, output repeat_res,
                    output line_end, output last, output error, input ready);
    modport sink   (input valid, input character, input repeat_res,
                    input line_end, input last, input error, output ready);
endinterface

interface grle_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [grle_pkg::CFG_IDX_W-1:0]  index;
    logic [grle_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/grle_cfg_regs.sv]
// Configuration register file of the grid run-length expander.
// Depends on grle_pkg; writes come from the configuration channel.
`timescale 1ns / 1ps

module grle_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [grle_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  logic [grle_pkg::CFG_DATA_W-1:0] i_wr_data,
    output grle_pkg::t_cfg                  o_cfg
);
    import grle_pkg::*;

    t_cfg r_cfg;

    // write one register per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_width     <= WIDTH_MIN;
            r_cfg.entry_line     <= '0;
            r_cfg.entry_place    <= '0;
            r_cfg.exit_line      <= '0;
            r_cfg.exit_place     <= '0;
            r_cfg.separator_byte <= 8'd0;
            r_cfg.wall_byte      <= 8'd88;
            r_cfg.path_byte      <= 8'd32;
        end else if (i_wr_en) begin
            case (t_cfg_idx'(i_wr_index))
                REG_LINE_WIDTH:  r_cfg.line_width     <= i_wr_data[WIDTH_W-1:0];
                REG_ENTRY_LINE:  r_cfg.entry_line     <= i_wr_data[LINE_W-1:0];
                REG_ENTRY_PLACE: r_cfg.entry_place    <= i_wr_data[PLACE_W-1:0];
                REG_EXIT_LINE:   r_cfg.exit_line      <= i_wr_data[LINE_W-1:0];
                REG_EXIT_PLACE:  r_cfg.exit_place     <= i_wr_data[PLACE_W-1:0];
                REG_SEPARATOR:   r_cfg.separator_byte <= i_wr_data[BYTE_W-1:0];
                REG_WALL:        r_cfg.wall_byte      <= i_wr_data[BYTE_W-1:0];
                REG_PATH:        r_cfg.path_byte      <= i_wr_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/grle_ctrl.sv]
// Controller of the grid run-length expander: sequences word intake,
// segment planning and result handoff. Depends on grle_pkg.
`timescale 1ns / 1ps

module grle_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  grle_pkg::t_sts i_sts,
    output grle_pkg::t_cmd o_cmd
);
    import grle_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = i_sts.word_ok ? ST_DIST : ST_SEND;
            end
            ST_DIST: n_state = ST_SEG;
            ST_SEG:  n_state = ST_SEND;
            ST_SEND: begin
                if (i_out_ready) n_state = i_sts.seg_last ? ST_IDLE : ST_DIST;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // commands and handshake outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_word = i_in_valid;
            end
            ST_CHECK: begin
                o_cmd.load_err = !i_sts.word_ok;
            end
            ST_DIST: o_cmd.calc_dist = 1'b1;
            ST_SEG:  o_cmd.load_seg  = 1'b1;
            ST_SEND: o_out_valid = 1'b1;
            default: ;
        endcase
    end

endmodule

[hw/rtl/grle_dpath.sv]
// Datapath of the grid run-length expander: word holding registers, grid
// position, distance planning and the segment output register.
// Depends on grle_pkg; driven by grle_ctrl commands.
`timescale 1ns / 1ps

module grle_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  grle_pkg::t_cfg                i_cfg,
    input  grle_pkg::t_cmd                i_cmd,
    output grle_pkg::t_sts                o_sts,
    input  logic [grle_pkg::BYTE_W-1:0]   i_lead_byte,
    input  logic [grle_pkg::BYTE_W-1:0]   i_symbol,
    input  logic [grle_pkg::BYTE_W-1:0]   i_count,
    output logic [grle_pkg::BYTE_W-1:0]   o_character,
    output logic [grle_pkg::REP_W-1:0]    o_repeat_res,
    output logic                          o_line_end,
    output logic                          o_last,
    output logic                          o_error
);
    import grle_pkg::*;

    // word registers
    logic [BYTE_W-1:0]  r_lead;
    logic [BYTE_W-1:0]  r_sym;
    logic [REP_W-1:0]   r_remain;
    // grid position
    logic [COL_W-1:0]   r_col;
    logic [LINE_W-1:0]  r_line;
    // planned distances
    logic               r_at_mark;
    logic [BYTE_W-1:0]  r_mark_ch;
    logic [WIDTH_W-1:0] r_end_dist;
    logic [WIDTH_W-1:0] r_entry_dist;
    logic [WIDTH_W-1:0] r_exit_dist;
    // output word
    logic [BYTE_W-1:0]  r_char;
    logic [REP_W-1:0]   r_rep;
    logic               r_le;
    logic               r_last;
    logic               r_err;

    logic [WIDTH_W-1:0] eff_width;
    logic [WIDTH_W-1:0] col_ext;
    logic [PLACE_W-1:0] col_wide;
    logic [WIDTH_W-1:0] end_dist;
    logic               entry_on_line;
    logic               exit_on_line;
    logic [PLACE_W-1:0] entry_mark;
    logic [PLACE_W-1:0] exit_mark;
    logic [PLACE_W-1:0] entry_diff;
    logic [PLACE_W-1:0] exit_diff;
    logic               at_entry;
    logic               at_exit;
    logic [WIDTH_W-1:0] entry_dist;
    logic [WIDTH_W-1:0] exit_dist;
    logic [WIDTH_W-1:0] min_a;
    logic [WIDTH_W-1:0] min_b;
    logic [WIDTH_W-1:0] min_all;
    logic [WIDTH_W-1:0] seg_len;
    logic               seg_break;
    logic [REP_W-1:0]   remain_nx;
    logic [WIDTH_W-1:0] col_sum;

    // clamp the line width to its legal range
    always_comb begin
        if (i_cfg.line_width < WIDTH_MIN) begin
            eff_width = WIDTH_MIN;
        end else if (i_cfg.line_width > WIDTH_MAX) begin
            eff_width = WIDTH_MAX;
        end else begin
            eff_width = i_cfg.line_width;
        end
    end

    // distances from the current column to line end and to each marker
    always_comb begin
        col_ext  = {1'b0, r_col};
        col_wide = {{(PLACE_W-COL_W){1'b0}}, r_col};
        end_dist = (col_ext < eff_width) ? (eff_width - col_ext) : 11'd1;

        entry_on_line = (r_line == i_cfg.entry_line) && (i_cfg.entry_place != '0);
        exit_on_line  = (r_line == i_cfg.exit_line) && (i_cfg.exit_place != '0);
        entry_mark    = i_cfg.entry_place - 16'd1;
        exit_mark     = i_cfg.exit_place - 16'd1;
        at_entry      = entry_on_line && (entry_mark == col_wide);
        at_exit       = exit_on_line && (exit_mark == col_wide);
        entry_diff    = entry_mark - col_wide;
        exit_diff     = exit_mark - col_wide;

        entry_dist = DIST_NONE;
        if (entry_on_line && (entry_mark > col_wide)
                && (entry_diff[PLACE_W-1:WIDTH_W] == '0)) begin
            entry_dist = entry_diff[WIDTH_W-1:0];
        end
        exit_dist = DIST_NONE;
        if (exit_on_line && (exit_mark > col_wide)
                && (exit_diff[PLACE_W-1:WIDTH_W] == '0)) begin
            exit_dist = exit_diff[WIDTH_W-1:0];
        end
    end

    // segment length: one marker cell, or the shortest of all limits
    always_comb begin
        min_a     = (r_end_dist < r_entry_dist) ? r_end_dist : r_entry_dist;
        min_b     = (r_exit_dist < {2'b00, r_remain}) ? r_exit_dist : {2'b00, r_remain};
        min_all   = (min_a < min_b) ? min_a : min_b;
        seg_len   = r_at_mark ? 11'd1 : min_all;
        seg_break = (seg_len == r_end_dist);
        remain_nx = r_remain - seg_len[REP_W-1:0];
        col_sum   = col_ext + seg_len;
    end

    // hold the accepted code word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word) begin
            r_lead   <= i_lead_byte;
            r_sym    <= i_symbol;
            r_remain <= {1'b0, i_count} + 9'd1;
        end else if (i_cmd.load_seg) begin
            r_remain <= remain_nx;
        end
    end

    // register the planned distances
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_dist) begin
            r_at_mark    <= at_entry || at_exit;
            r_mark_ch    <= at_entry ? CHAR_P : CHAR_K;
            r_end_dist   <= end_dist;
            r_entry_dist <= entry_dist;
            r_exit_dist  <= exit_dist;
        end
    end

    // advance the grid position by one segment
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_line <= 16'd1;
        end else if (i_cmd.load_seg) begin
            if (seg_break) begin
                r_col <= '0;
                if (r_line != LINE_MAX) r_line <= r_line + 16'd1;
            end else begin
                r_col <= col_sum[COL_W-1:0];
            end
        end
    end

    // load the output word: a segment or a reject
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= 1'b1;
        end else if (i_cmd.load_seg) begin
            r_char <= r_at_mark ? r_mark_ch : r_sym;
            r_rep  <= seg_len[REP_W-1:0];
            r_le   <= seg_break;
            r_last <= (remain_nx == '0);
            r_err  <= 1'b0;
        end else if (i_cmd.load_err) begin
            r_char <= '0;
            r_rep  <= '0;
            r_le   <= 1'b0;
            r_last <= 1'b1;
            r_err  <= 1'b1;
        end
    end

    assign o_sts.word_ok  = (r_lead == i_cfg.separator_byte)
                            && ((r_sym == i_cfg.wall_byte) || (r_sym == i_cfg.path_byte));
    assign o_sts.seg_last = r_last;

    assign o_character  = r_char;
    assign o_repeat_res = r_rep;
    assign o_line_end   = r_le;
    assign o_last       = r_last;
    assign o_error      = r_err;

endmodule

[hw/rtl/grid_run_length_expander_unit.sv]
// Grid run-length expander: top level joining register file, controller
// and datapath. Depends on grle_pkg, grle_if, grle_cfg_regs, grle_ctrl
// and grle_dpath.
//
// Usage:
//   i_word takes three-byte code words (lead_byte, symbol, count). Each
//   valid word expands to count+1 cells laid into a grid of line_width
//   columns; o_seg delivers them as segments (character, repeat_res,
//   line_end, last, error), split at the 'P'/'K' marker cells and at line
//   ends. A word with a bad lead byte or symbol gives one error segment
//   and leaves the grid position alone.
//   i_cfg writes register <index> with <data>; it is always ready. It is to
//   be written only while no word is in flight; the block does not enforce it.
// Timing:
//   One word at a time. After a word is accepted the controller checks it,
//   then for each segment plans the distances, picks the length and
//   presents the segment; an error word goes from the check straight to
//   presenting its error segment. The next segment of a word is planned
//   only after the previous one is taken.
//   The next word is accepted in the cycle after its last segment leaves.
// Reset and stalls:
//   i_rst_n (synchronous, active low) restores the register defaults,
//   column 0 and line 1. When o_seg.ready is low the segment register
//   holds its word and the block waits; nothing is lost or repeated.
`timescale 1ns / 1ps

module grid_run_length_expander_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    grle_word_if.sink i_word,
    grle_seg_if.source o_seg,
    grle_cfg_if.sink  i_cfg
);
    import grle_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    // configuration writes never stall
    assign i_cfg.ready = 1'b1;

    grle_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    grle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_word.valid),
        .o_in_ready  (i_word.ready),
        .o_out_valid (o_seg.valid),
        .i_out_ready (o_seg.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    grle_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_lead_byte  (i_word.lead_byte),
        .i_symbol     (i_word.symbol),
        .i_count      (i_word.count),
        .o_character  (o_seg.character),
        .o_repeat_res (o_seg.repeat_res),
        .o_line_end   (o_seg.line_end),
        .o_last       (o_seg.last),
        .o_error      (o_seg.error)
    );

endmodule

[tb/sv/grid_run_length_expander_unit_tb.sv]
// Self-checking testbench for grid_run_length_expander_unit: drives code words,
// predicts the segment stream with a behavioral grid model and checks every word.
// Depends on grle_pkg, the grle_if channel interfaces and the expander RTL.
`timescale 1ns / 1ps

module grid_run_length_expander_unit_tb;
    import grle_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 9;
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int LATENCY_SLACK  = 4;
    localparam int END_CYCLES     = 16;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int MAX_REPORTS    = 60;
    localparam int WORDS_PER_SET  = 14;
    localparam int SETS_PER_PHASE = 4;

    localparam logic [BYTE_W-1:0] WALL_RESET = 8'h58;
    localparam logic [BYTE_W-1:0] PATH_RESET = 8'h20;

    typedef struct packed {
        logic [BYTE_W-1:0] character;
        logic [REP_W-1:0]  repeat_res;
        logic              line_end;
        logic              last;
        logic              error;
    } t_segment;

    logic i_clk = 1'b0;
    logic i_rst_n;

    grle_word_if word_if ();
    grle_seg_if  seg_if ();
    grle_cfg_if  cfg_if ();

    grid_run_length_expander_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (word_if),
        .o_seg   (seg_if),
        .i_cfg   (cfg_if)
    );

    // shadow registers and grid position of the predictor
    t_cfg     grid_cfg;
    int       grid_column;
    int       grid_line;
    t_segment pending_segs_q[$];

    int   mismatch_count = 0;
    int   cycle_count    = 0;
    int   snd_idle_pct   = 0;
    int   rcv_stall_pct  = 0;
    logic holdoff_active = 1'b0;
    event holdoff_start;

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d segments outstanding", $time, pending_segs_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // segment receiver: random stalls, or held off entirely during a hold-off
    always @(negedge i_clk) begin
        if (holdoff_active) begin
            seg_if.ready = 1'b0;
        end else begin
            seg_if.ready = ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // count out a long hold-off; flag changes at posedge so the receiver sees it cleanly
    initial forever begin
        @(holdoff_start);
        @(posedge i_clk);
        holdoff_active = 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge i_clk);
        holdoff_active = 1'b0;
    end

    // compare each accepted segment with the oldest prediction
    always @(posedge i_clk) begin : seg_check
        t_segment seg_got;
        t_segment seg_want;
        if (i_rst_n && seg_if.valid && seg_if.ready) begin
            seg_got = '{seg_if.character, seg_if.repeat_res, seg_if.line_end,
                        seg_if.last, seg_if.error};
            if (pending_segs_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected segment char=%h rep=%0d le=%b last=%b err=%b",
                             $time, seg_got.character, seg_got.repeat_res,
                             seg_got.line_end, seg_got.last, seg_got.error);
            end else begin
                seg_want = pending_segs_q.pop_front();
                if (seg_got !== seg_want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: mismatch exp %h/%0d/%b/%b/%b got %h/%0d/%b/%b/%b",
                                 $time, seg_want.character, seg_want.repeat_res,
                                 seg_want.line_end, seg_want.last, seg_want.error,
                                 seg_got.character, seg_got.repeat_res,
                                 seg_got.line_end, seg_got.last, seg_got.error);
                end
            end
        end
    end

    // clamp the programmed width into the supported range
    function automatic int effective_width();
        int width;
        width = int'(grid_cfg.line_width);
        if (width < int'(WIDTH_MIN))
            width = int'(WIDTH_MIN);
        if (width > int'(WIDTH_MAX))
            width = int'(WIDTH_MAX);
        return width;
    endfunction

    // lay one code word into the grid and queue the segments it produces
    function automatic void expand_word(input logic [BYTE_W-1:0] lead,
                                        input logic [BYTE_W-1:0] sym,
                                        input logic [BYTE_W-1:0] count);
        t_segment          segs[$];
        t_segment          seg;
        int                width;
        int                run_len;
        logic [BYTE_W-1:0] run_char;
        logic [BYTE_W-1:0] cell_char;
        logic              run_open;
        logic              run_marker;
        logic              marker;
        run_open   = 1'b0;
        run_marker = 1'b0;
        run_char   = '0;
        run_len    = 0;
        // reject: one error segment, grid position untouched
        if (lead != grid_cfg.separator_byte ||
            (sym != grid_cfg.wall_byte && sym != grid_cfg.path_byte)) begin
            pending_segs_q.push_back('{character: '0, repeat_res: '0, line_end: 1'b0,
                                       last: 1'b1, error: 1'b1});
            return;
        end
        width = effective_width();
        for (int i = 0; i <= int'(count); i++) begin
            cell_char = sym;
            marker    = 1'b0;
            // entry marker wins over exit marker on the same cell
            if (grid_line == int'(grid_cfg.entry_line) && grid_cfg.entry_place != '0 &&
                grid_column == int'(grid_cfg.entry_place) - 1) begin
                cell_char = CHAR_P;
                marker    = 1'b1;
            end else if (grid_line == int'(grid_cfg.exit_line) && grid_cfg.exit_place != '0 &&
                         grid_column == int'(grid_cfg.exit_place) - 1) begin
                cell_char = CHAR_K;
                marker    = 1'b1;
            end
            // close the open run at a marker cell or a change of character
            if (run_open && (marker || run_marker || cell_char != run_char)) begin
                segs.push_back('{run_char, run_len[REP_W-1:0], 1'b0, 1'b0, 1'b0});
                run_open = 1'b0;
            end
            if (run_open) begin
                run_len++;
            end else begin
                run_open   = 1'b1;
                run_char   = cell_char;
                run_len    = 1;
                run_marker = marker;
            end
            // break the line once the column reaches the width or lies beyond it
            grid_column++;
            if (grid_column >= width) begin
                segs.push_back('{run_char, run_len[REP_W-1:0], 1'b1, 1'b0, 1'b0});
                run_open    = 1'b0;
                grid_column = 0;
                if (grid_line < int'(LINE_MAX))
                    grid_line++;
            end
        end
        if (run_open)
            segs.push_back('{run_char, run_len[REP_W-1:0], 1'b0, 1'b0, 1'b0});
        seg      = segs.pop_back();
        seg.last = 1'b1;
        segs.push_back(seg);
        foreach (segs[k])
            pending_segs_q.push_back(segs[k]);
    endfunction

    // offer one code word, idling first at the current rate
    task automatic send_word(input logic [BYTE_W-1:0] lead,
                             input logic [BYTE_W-1:0] sym,
                             input logic [BYTE_W-1:0] count);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            word_if.valid = 1'b0;
            @(negedge i_clk);
        end
        word_if.valid     = 1'b1;
        word_if.lead_byte = lead;
        word_if.symbol    = sym;
        word_if.count     = count;
        do @(posedge i_clk); while (!word_if.ready);
        expand_word(lead, sym, count);
    endtask

    // write one register and mirror it in the shadow copy
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = value;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            REG_LINE_WIDTH:  grid_cfg.line_width     = value[WIDTH_W-1:0];
            REG_ENTRY_LINE:  grid_cfg.entry_line     = value;
            REG_ENTRY_PLACE: grid_cfg.entry_place    = value;
            REG_EXIT_LINE:   grid_cfg.exit_line      = value;
            REG_EXIT_PLACE:  grid_cfg.exit_place     = value;
            REG_SEPARATOR:   grid_cfg.separator_byte = value[BYTE_W-1:0];
            REG_WALL:        grid_cfg.wall_byte      = value[BYTE_W-1:0];
            REG_PATH:        grid_cfg.path_byte      = value[BYTE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic place_markers(input logic [LINE_W-1:0] entry_ln,
                                 input logic [PLACE_W-1:0] entry_pl,
                                 input logic [LINE_W-1:0] exit_ln,
                                 input logic [PLACE_W-1:0] exit_pl);
        write_reg(REG_ENTRY_LINE, entry_ln);
        write_reg(REG_ENTRY_PLACE, entry_pl);
        write_reg(REG_EXIT_LINE, exit_ln);
        write_reg(REG_EXIT_PLACE, exit_pl);
    endtask

    // stop offering words and wait until every predicted segment has come back
    task automatic settle_block();
        @(negedge i_clk);
        word_if.valid = 1'b0;
        while (pending_segs_q.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY_SLACK) @(posedge i_clk);
    endtask

    // marker lines mostly near the current line so markers actually get hit
    function automatic logic [LINE_W-1:0] pick_marker_line();
        if ($urandom_range(7) == 0)
            return LINE_W'($urandom);
        return LINE_W'(grid_line + $urandom_range(0, 3));
    endfunction

    function automatic logic [PLACE_W-1:0] pick_marker_place(input int width);
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return PLACE_W'($urandom);
            default: return PLACE_W'($urandom_range(1, width));
        endcase
    endfunction

    task automatic randomize_grid_setup();
        logic [CFG_DATA_W-1:0] width_val;
        int                    width;
        case ($urandom_range(9))
            6:       width_val = CFG_DATA_W'($urandom_range(0, 7));
            7:       width_val = CFG_DATA_W'(WIDTH_MAX);
            8:       width_val = CFG_DATA_W'($urandom);
            9:       width_val = CFG_DATA_W'(11'h7FF);
            default: width_val = CFG_DATA_W'($urandom_range(8, 40));
        endcase
        write_reg(REG_LINE_WIDTH, width_val);
        write_reg(REG_SEPARATOR, CFG_DATA_W'($urandom_range(255)));
        write_reg(REG_WALL, CFG_DATA_W'($urandom_range(255)));
        write_reg(REG_PATH, CFG_DATA_W'($urandom_range(255)));
        width = effective_width();
        place_markers(pick_marker_line(), pick_marker_place(width),
                      pick_marker_line(), pick_marker_place(width));
    endtask

    // mostly well-formed words, some with a bad lead byte or symbol, some noise
    task automatic send_random_word();
        logic [BYTE_W-1:0] lead;
        logic [BYTE_W-1:0] sym;
        logic [BYTE_W-1:0] count;
        int                kind;
        kind  = $urandom_range(99);
        lead  = grid_cfg.separator_byte;
        sym   = $urandom_range(1) ? grid_cfg.wall_byte : grid_cfg.path_byte;
        count = $urandom_range(1) ? BYTE_W'($urandom_range(15)) : BYTE_W'($urandom_range(255));
        if (kind < 8) begin
            do lead = BYTE_W'($urandom); while (lead == grid_cfg.separator_byte);
        end else if (kind < 16) begin
            do sym = BYTE_W'($urandom);
            while (sym == grid_cfg.wall_byte || sym == grid_cfg.path_byte);
        end else if (kind < 20) begin
            lead = BYTE_W'($urandom);
            sym  = BYTE_W'($urandom);
        end
        send_word(lead, sym, count);
    endtask

    // reset register values: separator 0, wall 'X', path ' ', width 8
    task automatic test_default_setup();
        send_word(8'h00, WALL_RESET, 8'd0);
        send_word(8'h00, PATH_RESET, 8'd6);
        send_word(8'h00, WALL_RESET, 8'd255);
    endtask

    // bad lead, bad symbol, both; the following good word shows the position held
    task automatic test_rejected_words();
        send_word(8'h01, WALL_RESET, 8'd5);
        send_word(8'h00, 8'h00, 8'd5);
        send_word(8'hFF, 8'hFF, 8'hFF);
        send_word(8'h00, PATH_RESET, 8'd2);
    endtask

    task automatic test_field_extremes();
        settle_block();
        write_reg(REG_SEPARATOR, 16'h00FF);
        write_reg(REG_WALL, 16'h00FF);
        write_reg(REG_PATH, 16'h0000);
        send_word(8'hFF, 8'hFF, 8'hFF);
        send_word(8'hFF, 8'h00, 8'h00);
        send_word(8'h00, 8'hFF, 8'h00);
        send_word(8'hFF, WALL_RESET, 8'h00);
    endtask

    // widths below the minimum, above the maximum, and a column left beyond the width
    task automatic test_width_limits();
        settle_block();
        write_reg(REG_LINE_WIDTH, 16'd0);
        send_word(8'hFF, 8'h00, 8'd20);
        settle_block();
        write_reg(REG_LINE_WIDTH, 16'd7);
        send_word(8'hFF, 8'hFF, 8'd9);
        settle_block();
        write_reg(REG_LINE_WIDTH, 16'h07FF);
        send_word(8'hFF, 8'h00, 8'd255);
        send_word(8'hFF, 8'hFF, 8'd255);
        settle_block();
        write_reg(REG_LINE_WIDTH, CFG_DATA_W'(WIDTH_MAX));
        send_word(8'hFF, 8'h00, 8'd255);
        while (grid_column < 16)
            send_word(8'hFF, 8'hFF, 8'd255);
        settle_block();
        write_reg(REG_LINE_WIDTH, 16'd8);
        send_word(8'hFF, 8'h00, 8'd3);
    endtask

    task automatic test_marker_cells();
        settle_block();
        write_reg(REG_LINE_WIDTH, 16'd16);
        write_reg(REG_WALL, CFG_DATA_W'(CHAR_P));
        // entry and exit apart on the next line
        place_markers(LINE_W'(grid_line + 1), 16'd3, LINE_W'(grid_line + 1), 16'd6);
        send_word(8'hFF, 8'h00, 8'd47);
        // both on one cell, symbol byte equal to the entry character
        settle_block();
        place_markers(LINE_W'(grid_line + 1), 16'd9, LINE_W'(grid_line + 1), 16'd9);
        send_word(8'hFF, CHAR_P, 8'd47);
        // place zero names no column
        settle_block();
        place_markers(LINE_W'(grid_line), 16'd0, LINE_W'(grid_line), 16'd0);
        send_word(8'hFF, 8'h00, 8'd40);
        // markers on the first and the last column of a line
        settle_block();
        place_markers(LINE_W'(grid_line + 1), 16'd1, LINE_W'(grid_line + 1), 16'd16);
        send_word(8'hFF, CHAR_P, 8'd47);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        for (int set_idx = 0; set_idx < SETS_PER_PHASE; set_idx++) begin
            settle_block();
            snd_idle_pct  = idle_pct;
            rcv_stall_pct = stall_pct;
            randomize_grid_setup();
            for (int k = 0; k < WORDS_PER_SET; k++)
                send_random_word();
        end
    endtask

    // hold the receiver off while words keep coming, so the input stalls
    task automatic test_input_backpressure();
        settle_block();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        randomize_grid_setup();
        -> holdoff_start;
        for (int k = 0; k < 12; k++)
            send_random_word();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        word_if.valid     = 1'b0;
        word_if.lead_byte = '0;
        word_if.symbol    = '0;
        word_if.count     = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = REG_LINE_WIDTH;
        cfg_if.data       = '0;
        seg_if.ready      = 1'b0;

        grid_cfg            = '0;
        grid_cfg.line_width = WIDTH_MIN;
        grid_cfg.wall_byte  = WALL_RESET;
        grid_cfg.path_byte  = PATH_RESET;
        grid_column         = 0;
        grid_line           = 1;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_setup();
        test_rejected_words();
        test_field_extremes();
        test_width_limits();
        test_marker_cells();
        test_random_traffic(0, 0);
        test_random_traffic(64, 0);
        test_random_traffic(0, 64);
        test_random_traffic(34, 34);
        test_input_backpressure();

        settle_block();
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_segs_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/grle_pkg.sv
hw/rtl/grle_if.sv
hw/rtl/grle_cfg_regs.sv
hw/rtl/grle_ctrl.sv
hw/rtl/grle_dpath.sv
hw/rtl/grid_run_length_expander_unit.sv
tb/sv/grid_run_length_expander_unit_tb.sv
